### hdl/tked_pkg.sv
package tked_pkg;

   // Key codes on the result channel
   localparam logic [4:0] KEY_PLAIN     = 5'd0;
   localparam logic [4:0] KEY_INTR      = 5'd1;
   localparam logic [4:0] KEY_REVERSE   = 5'd2;
   localparam logic [4:0] KEY_DELBEGIN  = 5'd3;
   localparam logic [4:0] KEY_DELWORD   = 5'd4;
   localparam logic [4:0] KEY_BACKSPACE = 5'd5;
   localparam logic [4:0] KEY_UP        = 5'd6;
   localparam logic [4:0] KEY_DOWN      = 5'd7;
   localparam logic [4:0] KEY_RIGHT     = 5'd8;
   localparam logic [4:0] KEY_LEFT      = 5'd9;
   localparam logic [4:0] KEY_HOME      = 5'd10;
   localparam logic [4:0] KEY_END       = 5'd11;
   localparam logic [4:0] KEY_INSERT    = 5'd12;
   localparam logic [4:0] KEY_DEL       = 5'd13;
   localparam logic [4:0] KEY_PGUP      = 5'd14;
   localparam logic [4:0] KEY_PGDN      = 5'd15;
   localparam logic [4:0] KEY_RWORD     = 5'd16;
   localparam logic [4:0] KEY_LWORD     = 5'd17;

   // Byte codes
   localparam logic [7:0] CH_CTRL_C   = 8'd3;
   localparam logic [7:0] CH_CTRL_R   = 8'd18;
   localparam logic [7:0] CH_CTRL_U   = 8'd21;
   localparam logic [7:0] CH_ESC      = 8'd27;
   localparam logic [7:0] CH_DEL      = 8'd127;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ONE      = 8'h31;
   localparam logic [7:0] CH_FIVE     = 8'h35;
   localparam logic [7:0] CH_SIX      = 8'h36;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_B        = 8'h42;
   localparam logic [7:0] CH_C        = 8'h43;
   localparam logic [7:0] CH_D        = 8'h44;
   localparam logic [7:0] CH_F        = 8'h46;
   localparam logic [7:0] CH_H        = 8'h48;

   // Pending-sequence flags
   typedef struct packed {
      logic       escape_seen;
      logic       bracket_seen;
      logic [2:0] digit_code;
      logic       semicolon_seen;
      logic       modifier_five_seen;
   } seq_state_type;

   // Decoder result toward the output register
   typedef struct packed {
      logic       emit;
      logic [4:0] key_kind;
      logic [7:0] char_value;
   } dec_result_type;

   // ESC [ n ~ key table
   function automatic logic [4:0] digit_key(input logic [2:0] code);
      logic [4:0] k;
      unique case (code)
         3'd1:    k = KEY_HOME;
         3'd2:    k = KEY_INSERT;
         3'd3:    k = KEY_DEL;
         3'd4:    k = KEY_END;
         3'd5:    k = KEY_PGUP;
         3'd6:    k = KEY_PGDN;
         default: k = KEY_PLAIN;
      endcase
      return k;
   endfunction

endpackage

### hdl/tked_decode.sv
module tked_decode (
   input  tked_pkg::seq_state_type  cur_state,
   input  logic [7:0]               in_byte,
   output tked_pkg::seq_state_type  nxt_state,
   output tked_pkg::dec_result_type result
);

   always_comb begin
      nxt_state = cur_state;
      result    = '0;

      priority if (in_byte == tked_pkg::CH_CTRL_C) begin
         result.emit     = 1'b1;
         result.key_kind = tked_pkg::KEY_INTR;
      end else if (in_byte == tked_pkg::CH_CTRL_R) begin
         result.emit     = 1'b1;
         result.key_kind = tked_pkg::KEY_REVERSE;
      end else if (in_byte == tked_pkg::CH_CTRL_U) begin
         result.emit     = 1'b1;
         result.key_kind = tked_pkg::KEY_DELBEGIN;
      end else if (in_byte == tked_pkg::CH_ESC) begin
         nxt_state.escape_seen = 1'b1;
      end else if (in_byte == tked_pkg::CH_DEL) begin
         result.emit     = 1'b1;
         result.key_kind = cur_state.escape_seen ? tked_pkg::KEY_DELWORD
                                                 : tked_pkg::KEY_BACKSPACE;
      end else if (cur_state.escape_seen) begin
         nxt_state.escape_seen = 1'b0;
         if (in_byte == tked_pkg::CH_LBRACKET) begin
            nxt_state.bracket_seen = 1'b1;
         end
      end else if (cur_state.bracket_seen) begin
         nxt_state.bracket_seen = 1'b0;
         priority if (in_byte == tked_pkg::CH_A) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::KEY_UP;
         end else if (in_byte == tked_pkg::CH_B) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::KEY_DOWN;
         end else if (in_byte == tked_pkg::CH_C) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::KEY_RIGHT;
         end else if (in_byte == tked_pkg::CH_D) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::KEY_LEFT;
         end else if (in_byte == tked_pkg::CH_H) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::KEY_HOME;
         end else if (in_byte == tked_pkg::CH_F) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::KEY_END;
         end else if (in_byte >= tked_pkg::CH_ONE && in_byte <= tked_pkg::CH_SIX) begin
            // '1'..'6' carry their value in the low three bits
            nxt_state.digit_code = in_byte[2:0];
         end else begin
            nxt_state.digit_code = cur_state.digit_code;
         end
      end else if (cur_state.digit_code != 3'd0) begin
         if (in_byte == tked_pkg::CH_TILDE) begin
            result.emit     = 1'b1;
            result.key_kind = tked_pkg::digit_key(cur_state.digit_code);
         end else begin
            nxt_state.digit_code = 3'd0;
            if (in_byte == tked_pkg::CH_SEMI) begin
               nxt_state.semicolon_seen = 1'b1;
            end
         end
      end else if (cur_state.semicolon_seen) begin
         // control keys, ESC and DEL aside, swallow everything until the modifier digit
         if (in_byte == tked_pkg::CH_FIVE) begin
            nxt_state.semicolon_seen     = 1'b0;
            nxt_state.modifier_five_seen = 1'b1;
         end
      end else if (cur_state.modifier_five_seen && in_byte == tked_pkg::CH_C) begin
         result.emit     = 1'b1;
         result.key_kind = tked_pkg::KEY_RWORD;
      end else if (cur_state.modifier_five_seen && in_byte == tked_pkg::CH_D) begin
         result.emit     = 1'b1;
         result.key_kind = tked_pkg::KEY_LWORD;
      end else begin
         result.emit       = 1'b1;
         result.key_kind   = tked_pkg::KEY_PLAIN;
         result.char_value = in_byte;
      end

      // any emitted key ends the sequence
      if (result.emit) begin
         nxt_state = '0;
      end
   end

endmodule

### hdl/terminal_key_escape_decoder_top.sv
// Terminal key decoder. Takes one raw terminal byte per req_ transaction and
// returns at most one rsp_ transaction with a key code and, for plain
// characters, the byte itself. Ctrl-C, Ctrl-R, Ctrl-U and DEL decode at once
// (ESC DEL is delete-word); ESC [ A/B/C/D/H/F, ESC [ 1..6 ~ and ESC [ 1 ; 5 C/D
// decode the arrow, home/end, edit-pad and word-move keys. Bytes that only
// advance a sequence, and sequences that are not recognized, give no result,
// except that an ordinary byte other than C or D after ESC [ n ; 5 comes out
// as a plain character. Throughput is one byte per clock while no byte that
// produces a key is held back. A byte is registered in the input register,
// the decode and flag update are a single compare-and-select pass, and the
// key lands in the output register, which drives rsp_. A byte that produces
// a key waits in the input register only while the output register is full
// and stalled; a byte that produces nothing is never held back by the result side.
module terminal_key_escape_decoder_top (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_key_kind,
   output logic [7:0] rsp_char_value
);

   // Input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // Sequence flags
   tked_pkg::seq_state_type state_ff;
   tked_pkg::seq_state_type state_in;
   tked_pkg::seq_state_type dec_state;
   tked_pkg::dec_result_type dec_result;

   // Output register
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [4:0] out_kind_ff;
   logic [7:0] out_char_ff;

   logic out_free;
   logic advance;
   logic req_take;

   tked_decode u_decode (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .nxt_state (dec_state),
      .result    (dec_result)
   );

   // Output slot is free when empty or being drained this cycle.
   assign out_free = !out_valid_ff || !rsp_stall;
   // The held byte retires when it needs no slot or one is free.
   assign advance  = in_valid_ff && (!dec_result.emit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      state_in    = advance ? dec_state : state_ff;
      if (advance && dec_result.emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && dec_result.emit) begin
         out_kind_ff <= dec_result.key_kind;
         out_char_ff <= dec_result.char_value;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_kind   = out_kind_ff;
   assign rsp_char_value = out_char_ff;

endmodule

### tb/terminal_key_escape_decoder_top_tb.sv
`timescale 1ns / 100ps

// One decoded key as it should appear on the rsp_ channel
typedef struct packed {
   logic [4:0] kind;
   logic [7:0] value;
} key_event_type;

// Tracks the decoder's pending-sequence flags and queues the keys each
// accepted byte should produce, in order.
class key_scoreboard;
   bit             esc_pending;
   bit             bracket_pending;
   bit   [2:0]     pad_digit;
   bit             semi_pending;
   bit             five_pending;
   key_event_type  expected_keys[$];
   int unsigned    errors;

   // Queue a key and drop every pending flag
   function void push_key(logic [4:0] kind, logic [7:0] value);
      key_event_type ev;
      ev.kind  = kind;
      ev.value = (kind == tked_pkg::KEY_PLAIN) ? value : 8'd0;
      expected_keys.push_back(ev);
      esc_pending     = 1'b0;
      bracket_pending = 1'b0;
      pad_digit       = 3'd0;
      semi_pending    = 1'b0;
      five_pending    = 1'b0;
   endfunction

   // ESC [ n ~ edit-pad keys
   function logic [4:0] pad_key(bit [2:0] digit);
      case (digit)
         3'd1:    return tked_pkg::KEY_HOME;
         3'd2:    return tked_pkg::KEY_INSERT;
         3'd3:    return tked_pkg::KEY_DEL;
         3'd4:    return tked_pkg::KEY_END;
         3'd5:    return tked_pkg::KEY_PGUP;
         3'd6:    return tked_pkg::KEY_PGDN;
         default: return tked_pkg::KEY_PLAIN;
      endcase
   endfunction

   function void note_byte(logic [7:0] b);
      case (b)
         tked_pkg::CH_CTRL_C: push_key(tked_pkg::KEY_INTR, b);
         tked_pkg::CH_CTRL_R: push_key(tked_pkg::KEY_REVERSE, b);
         tked_pkg::CH_CTRL_U: push_key(tked_pkg::KEY_DELBEGIN, b);
         tked_pkg::CH_ESC:    esc_pending = 1'b1;
         tked_pkg::CH_DEL:
            push_key(esc_pending ? tked_pkg::KEY_DELWORD : tked_pkg::KEY_BACKSPACE, b);
         default: begin
            if (esc_pending) begin
               // bracket flag is set only here
               esc_pending = 1'b0;
               if (b == tked_pkg::CH_LBRACKET) bracket_pending = 1'b1;
            end else if (bracket_pending) begin
               bracket_pending = 1'b0;
               case (b)
                  tked_pkg::CH_A: push_key(tked_pkg::KEY_UP, b);
                  tked_pkg::CH_B: push_key(tked_pkg::KEY_DOWN, b);
                  tked_pkg::CH_C: push_key(tked_pkg::KEY_RIGHT, b);
                  tked_pkg::CH_D: push_key(tked_pkg::KEY_LEFT, b);
                  tked_pkg::CH_H: push_key(tked_pkg::KEY_HOME, b);
                  tked_pkg::CH_F: push_key(tked_pkg::KEY_END, b);
                  default: begin
                     if (b >= tked_pkg::CH_ONE && b <= tked_pkg::CH_SIX)
                        pad_digit = 3'(b - tked_pkg::CH_ONE + 8'd1);
                  end
               endcase
            end else if (pad_digit != 3'd0) begin
               if (b == tked_pkg::CH_TILDE) begin
                  push_key(pad_key(pad_digit), b);
               end else begin
                  if (b == tked_pkg::CH_SEMI) semi_pending = 1'b1;
                  pad_digit = 3'd0;
               end
            end else if (semi_pending) begin
               // everything but a five is swallowed here
               if (b == tked_pkg::CH_FIVE) begin
                  semi_pending = 1'b0;
                  five_pending = 1'b1;
               end
            end else if (five_pending && b == tked_pkg::CH_C) begin
               push_key(tked_pkg::KEY_RWORD, b);
            end else if (five_pending && b == tked_pkg::CH_D) begin
               push_key(tked_pkg::KEY_LWORD, b);
            end else begin
               push_key(tked_pkg::KEY_PLAIN, b);
            end
         end
      endcase
   endfunction

   function void check_key(logic [4:0] kind, logic [7:0] value);
      key_event_type ev;
      if (expected_keys.size() == 0) begin
         $error("unexpected key: key_kind %0d char_value %0d", kind, value);
         errors++;
         return;
      end
      ev = expected_keys.pop_front();
      if (kind !== ev.kind) begin
         $error("key_kind: expected %0d, actual %0d", ev.kind, kind);
         errors++;
      end
      if (value !== ev.value) begin
         $error("char_value: expected %0d, actual %0d", ev.value, value);
         errors++;
      end
   endfunction
endclass

module terminal_key_escape_decoder_top_tb;

   // Byte codes the package does not name
   localparam logic [7:0] CH_ZERO = 8'h30;
   // Final bytes of ESC [ x sequences
   localparam logic [7:0] ARROW_KEYS [6] = '{tked_pkg::CH_A, tked_pkg::CH_B, tked_pkg::CH_C,
                                             tked_pkg::CH_D, tked_pkg::CH_H, tked_pkg::CH_F};
   // Bytes per traffic phase
   localparam int PHASE_BYTES = 250;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [4:0] rsp_key_kind;
   logic [7:0] rsp_char_value;

   // Idle odds out of 100, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned phase_items;

   key_scoreboard sb = new();

   terminal_key_escape_decoder_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_kind   (rsp_key_kind),
      .rsp_char_value (rsp_char_value)
   );

   always #4 clock = ~clock;

   // Run limit: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // Result side. Outputs are read right after the edge, so they still hold
   // the values the edge sampled; a transaction counts when valid was high
   // and our own stall was low. Stall is redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_key(rsp_key_kind, rsp_char_value);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // One byte transaction: optional idle cycles, then hold valid and the
   // byte until the edge that takes them. Returns at that edge, so the next
   // call sets valid and data once in this step.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
      phase_items++;
   endtask

   // A mix of well-formed key sequences with random parts, raw noise, broken
   // sequences and control keys cutting into a sequence.
   task automatic send_token();
      logic [7:0] seq[$];
      logic [7:0] pad;
      logic [7:0] any;
      logic [7:0] ctrl;
      int unsigned pick;
      pick = $urandom_range(99);
      pad  = tked_pkg::CH_ONE + 8'($urandom_range(5));
      any  = 8'($urandom_range(255));
      case ($urandom_range(3))
         0:       ctrl = tked_pkg::CH_CTRL_C;
         1:       ctrl = tked_pkg::CH_CTRL_R;
         2:       ctrl = tked_pkg::CH_CTRL_U;
         default: ctrl = tked_pkg::CH_DEL;
      endcase
      if (pick < 30) begin
         seq = {any};
      end else if (pick < 38) begin
         if ($urandom_range(1)) seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, pad, ctrl};
         else seq = {ctrl};
      end else if (pick < 43) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_DEL};
      end else if (pick < 58) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, ARROW_KEYS[$urandom_range(5)]};
      end else if (pick < 70) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, pad, tked_pkg::CH_TILDE};
      end else if (pick < 78) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET,
                ($urandom_range(1) ? tked_pkg::CH_ONE : pad),
                tked_pkg::CH_SEMI, tked_pkg::CH_FIVE,
                ($urandom_range(1) ? tked_pkg::CH_C : tked_pkg::CH_D)};
      end else if (pick < 82) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_ONE,
                tked_pkg::CH_SEMI, tked_pkg::CH_FIVE, any};
      end else if (pick < 86) begin
         seq = {tked_pkg::CH_ESC, any};
      end else if (pick < 89) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, any};
      end else if (pick < 92) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, pad, any};
      end else if (pick < 95) begin
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET,
                ARROW_KEYS[$urandom_range(5)]};
      end else begin
         // junk between semicolon and five is swallowed unless it is a five, a control key, ESC or DEL
         seq = {tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, pad, tked_pkg::CH_SEMI, any,
                tked_pkg::CH_FIVE, any};
      end
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   initial begin
      logic [7:0] directed[$];

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes, control keys, ESC DEL
      directed = {8'h00, 8'hFF, tked_pkg::CH_CTRL_C, tked_pkg::CH_CTRL_R,
                  tked_pkg::CH_CTRL_U, tked_pkg::CH_DEL, tked_pkg::CH_ESC, tked_pkg::CH_DEL};
      // Arrows, home, end
      for (int n = 0; n < 6; n++)
         directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, ARROW_KEYS[n]};
      // Edit pad ESC [ 1..6 ~
      for (int n = 0; n < 6; n++)
         directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET,
                     8'(tked_pkg::CH_ONE + n), tked_pkg::CH_TILDE};
      // Word moves
      directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_ONE,
                  tked_pkg::CH_SEMI, tked_pkg::CH_FIVE, tked_pkg::CH_C,
                  tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_ONE,
                  tked_pkg::CH_SEMI, tked_pkg::CH_FIVE, tked_pkg::CH_D};
      // Five then another byte: plain char; semicolon after any digit
      directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_SIX,
                  tked_pkg::CH_SEMI, tked_pkg::CH_FIVE, tked_pkg::CH_H};
      // Non-five bytes after semicolon get swallowed
      directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_ONE,
                  tked_pkg::CH_SEMI, tked_pkg::CH_A, tked_pkg::CH_TILDE,
                  tked_pkg::CH_FIVE, tked_pkg::CH_D};
      // Unknown byte after ESC, after ESC [, after a digit
      directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_A,
                  tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_TILDE,
                  tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_SIX, tked_pkg::CH_A};
      // Zero is no digit: bracket dropped, tilde comes out plain
      directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, CH_ZERO,
                  tked_pkg::CH_TILDE};
      // Repeated ESC; control keys cutting into a sequence
      directed = {directed, tked_pkg::CH_ESC, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET,
                  tked_pkg::CH_B,
                  tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET, tked_pkg::CH_FIVE,
                  tked_pkg::CH_CTRL_C, tked_pkg::CH_ESC, tked_pkg::CH_LBRACKET,
                  tked_pkg::CH_DEL};

      // Phases: no idling, sender idle, receiver stalling, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 64;
            end
            default: begin
               send_idle_pct = 11;
               stall_pct     = 11;
            end
         endcase
         phase_items = 0;
         if (ph == 0) foreach (directed[i]) send_byte(directed[i]);
         while (phase_items < PHASE_BYTES) send_token();
         // Hold off the sender until every pending key is back
         req_valid <= 1'b0;
         while (sb.expected_keys.size() != 0) @(posedge clock);
         @(posedge clock);
      end

      // Drain: no stalls, then keep watching to catch stray results
      stall_pct = 0;
      while (sb.expected_keys.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.expected_keys.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hdl/tked_pkg.sv
hdl/tked_decode.sv
hdl/terminal_key_escape_decoder_top.sv
tb/terminal_key_escape_decoder_top_tb.sv
